// ===== hw/rtl/lsj_pkg.sv =====
// ----------------------------------------------------------------------------
// lsj_pkg: shared types and constants of the Laplace subdomain Jacobi solver
// Grid dimensions, Q15.24 value width, payload structs, controller states
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lsj_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int VALUE_W   = 40;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROWCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int COLCNT_W  = $clog2(MAX_COLS + 1);
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int MAX_LINE  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int LINECNT_W = $clog2(MAX_LINE + 1);
  localparam int SUM_W     = VALUE_W + $clog2(MAX_LINE);
  localparam int QSUM_W    = VALUE_W + 2;
  localparam int GAP_W     = VALUE_W + 1;
  localparam int MIN_DIM   = 3;

  localparam int DIM_W      = 5;
  localparam int SWEEP_W    = 16;
  localparam int TOL_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIM_W-1:0]   ROWS_RESET       = 5'd5;
  localparam logic [DIM_W-1:0]   COLS_RESET       = 5'd5;
  localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RESET = 16'd500;
  localparam logic [TOL_W-1:0]   SWEEP_TOL_RESET  = 24'd17;
  localparam logic [TOL_W-1:0]   EDGE_TOL_RESET   = 24'd168;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS       = 3'd0,
    REG_COLS       = 3'd1,
    REG_MAX_SWEEPS = 3'd2,
    REG_SWEEP_TOL  = 3'd3,
    REG_EDGE_TOL   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] bottom_value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] left_average;
    logic signed [VALUE_W-1:0] right_average;
    logic signed [VALUE_W-1:0] top_average;
    logic signed [VALUE_W-1:0] bottom_average;
    logic                      settled;
  } out_t;

  typedef struct packed {
    logic [ROWCNT_W-1:0] rows;
    logic [COLCNT_W-1:0] cols;
    logic [SWEEP_W-1:0]  max_sweeps;
    logic [TOL_W-1:0]    sweep_tol;
    logic [TOL_W-1:0]    edge_tol;
  } cfg_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_UD,
    RD_LR,
    RD_C,
    RD_ECOL,
    RD_EROW
  } rd_phase_t;

  typedef struct packed {
    rd_phase_t        phase;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             load_in;
    logic             bank_clr;
    logic             init_wr;
    logic             calc;
    logic             wr_cell;
    logic             sweep_clr;
    logic             swap;
    logic             div_start;
    logic [1:0]       div_sel;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic worst_below;
    logic div_done;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CALC,
    S_WR,
    S_SWEEP_END,
    S_MEAN_COL,
    S_MEAN_ROW,
    S_MEAN_TAIL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_COLS + int'(col));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsj_divider.sv =====
// ----------------------------------------------------------------------------
// lsj_divider: signed line-sum by cell-count divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lsj_divider (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [lsj_pkg::SUM_W-1:0]   dividend,
  input  wire logic [lsj_pkg::LINECNT_W-1:0]      divisor,
  output logic signed [lsj_pkg::VALUE_W-1:0]      quotient,
  output logic                                    done
);
  import lsj_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [SUM_W-1:0]     quo;
  logic [LINECNT_W-1:0] rem;
  logic [LINECNT_W-1:0] dq;
  logic                 neg;
  logic [LINECNT_W:0]   trial;
  logic                 fits;
  logic [LINECNT_W:0]   trial_sub;

  always_comb begin
    trial     = {rem, quo[SUM_W-1]};
    fits      = trial >= {1'b0, dq};
    trial_sub = trial - {1'b0, dq};
    quotient  = neg ? -VALUE_W'(quo) : VALUE_W'(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(SUM_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
      dq  <= divisor;
    end else if (running) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? trial_sub[LINECNT_W-1:0] : trial[LINECNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsj_datapath.sv =====
// ----------------------------------------------------------------------------
// lsj_datapath: grid banks, stencil arithmetic and edge means
// Two ping-pong grid banks, neighbor capture, quarter sum, largest change,
// edge line accumulators, shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsj_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lsj_pkg::cfg_t    cfg,
  input  wire lsj_pkg::cmd_t    cmd,
  input  wire lsj_pkg::in_t     item,
  output lsj_pkg::status_t      status,
  output lsj_pkg::out_t         result
);
  import lsj_pkg::*;

  logic signed [VALUE_W-1:0] bank0 [MEM_DEPTH];
  logic signed [VALUE_W-1:0] bank1 [MEM_DEPTH];
  logic signed [VALUE_W-1:0] rd00, rd01, rd10, rd11;
  logic signed [VALUE_W-1:0] rdata0, rdata1;

  in_t                       item_q;
  logic                      cur;
  rd_phase_t                 phase_q;
  logic [ADDR_W-1:0]         a0, a1, waddr;
  logic [ROW_W-1:0]          row_up, row_dn, row_b;
  logic [COL_W-1:0]          col_lf, col_rt, col_r;
  logic signed [VALUE_W-1:0] init_val, new_val, wdata;
  logic                      we0, we1;

  logic signed [VALUE_W-1:0] up, down, lf, rt, center;
  logic signed [QSUM_W-1:0]  qsum;
  logic signed [GAP_W-1:0]   diff;
  logic [GAP_W-1:0]          gap, worst;

  logic signed [SUM_W-1:0]   acc [4];
  logic signed [VALUE_W-1:0] avg [4];
  logic [1:0]                sel_q;
  logic signed [SUM_W-1:0]   div_num;
  logic [LINECNT_W-1:0]      div_den;
  logic signed [VALUE_W-1:0] div_q;
  logic                      div_done;

  logic signed [GAP_W-1:0]   edge_diff [4];
  logic [GAP_W-1:0]          edge_gap [4];
  logic signed [VALUE_W-1:0] edge_ref [4];
  logic                      settled;
  logic                      in_rows, in_cols;

  // Addresses
  always_comb begin
    row_up = cmd.row - ROW_W'(1);
    row_dn = cmd.row + ROW_W'(1);
    col_lf = cmd.col - COL_W'(1);
    col_rt = cmd.col + COL_W'(1);
    row_b  = ROW_W'(cfg.rows - ROWCNT_W'(2));
    col_r  = COL_W'(cfg.cols - COLCNT_W'(2));
    waddr  = cell_addr(cmd.row, cmd.col);
    case (cmd.phase)
      RD_UD: begin
        a0 = cell_addr(row_up, cmd.col);
        a1 = cell_addr(row_dn, cmd.col);
      end
      RD_LR: begin
        a0 = cell_addr(cmd.row, col_lf);
        a1 = cell_addr(cmd.row, col_rt);
      end
      RD_ECOL: begin
        a0 = cell_addr(cmd.row, COL_W'(1));
        a1 = cell_addr(cmd.row, col_r);
      end
      RD_EROW: begin
        a0 = cell_addr(ROW_W'(1), cmd.col);
        a1 = cell_addr(row_b, cmd.col);
      end
      default: begin
        a0 = waddr;
        a1 = waddr;
      end
    endcase
  end

  // Boundary pattern: top and bottom rows take the corners
  always_comb begin
    in_rows = ROWCNT_W'(cmd.row) < cfg.rows;
    in_cols = COLCNT_W'(cmd.col) < cfg.cols;
    if (cmd.row == '0 && in_cols) begin
      init_val = item_q.top_value;
    end else if (ROWCNT_W'(cmd.row) == cfg.rows - ROWCNT_W'(1) && in_cols) begin
      init_val = item_q.bottom_value;
    end else if (cmd.col == '0 && in_rows) begin
      init_val = item_q.left_value;
    end else if (COLCNT_W'(cmd.col) == cfg.cols - COLCNT_W'(1) && in_rows) begin
      init_val = item_q.right_value;
    end else begin
      init_val = '0;
    end
  end

  always_comb begin
    new_val = qsum[QSUM_W-1:2];
    diff    = GAP_W'(new_val) - GAP_W'(center);
    gap     = diff[GAP_W-1] ? GAP_W'(-diff) : GAP_W'(diff);
    wdata   = cmd.init_wr ? init_val : new_val;
    we0     = cmd.init_wr || (cmd.wr_cell && cur);
    we1     = cmd.init_wr || (cmd.wr_cell && !cur);
    rdata0  = cur ? rd10 : rd00;
    rdata1  = cur ? rd11 : rd01;
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[waddr] <= wdata;
    end
    rd00 <= bank0[a0];
    rd01 <= bank0[a1];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      bank1[waddr] <= wdata;
    end
    rd10 <= bank1[a0];
    rd11 <= bank1[a1];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q <= RD_NONE;
      cur     <= 1'b0;
      worst   <= '0;
    end else begin
      phase_q <= cmd.phase;
      if (cmd.bank_clr) begin
        cur <= 1'b0;
      end else if (cmd.swap) begin
        cur <= !cur;
      end
      if (cmd.sweep_clr) begin
        worst <= '0;
      end else if (cmd.wr_cell && gap > worst) begin
        worst <= gap;
      end
    end
  end

  // Capture read data in the cycle after its read was issued
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_q <= item;
      for (int n = 0; n < 4; n++) begin
        acc[n] <= '0;
      end
    end
    case (phase_q)
      RD_UD: begin
        up   <= rdata0;
        down <= rdata1;
      end
      RD_LR: begin
        lf <= rdata0;
        rt <= rdata1;
      end
      RD_C: center <= rdata0;
      RD_ECOL: begin
        acc[0] <= acc[0] + SUM_W'(rdata0);
        acc[1] <= acc[1] + SUM_W'(rdata1);
      end
      RD_EROW: begin
        acc[2] <= acc[2] + SUM_W'(rdata0);
        acc[3] <= acc[3] + SUM_W'(rdata1);
      end
      default: ;
    endcase
    if (cmd.calc) begin
      qsum <= QSUM_W'(up) + QSUM_W'(down) + QSUM_W'(lf) + QSUM_W'(rt);
    end
  end

  // Edge means
  always_comb begin
    div_num = acc[cmd.div_sel];
    div_den = (cmd.div_sel < 2'd2) ? LINECNT_W'(cfg.rows) : LINECNT_W'(cfg.cols);
  end

  lsj_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_q <= cmd.div_sel;
    end
    if (div_done) begin
      avg[sel_q] <= div_q;
    end
  end

  always_comb begin
    edge_ref[0] = item_q.left_value;
    edge_ref[1] = item_q.right_value;
    edge_ref[2] = item_q.top_value;
    edge_ref[3] = item_q.bottom_value;
    settled = 1'b1;
    for (int n = 0; n < 4; n++) begin
      edge_diff[n] = GAP_W'(avg[n]) - GAP_W'(edge_ref[n]);
      edge_gap[n]  = edge_diff[n][GAP_W-1] ? GAP_W'(-edge_diff[n]) : GAP_W'(edge_diff[n]);
      if (edge_gap[n] > GAP_W'(cfg.edge_tol)) begin
        settled = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.left_average   <= avg[0];
      result.right_average  <= avg[1];
      result.top_average    <= avg[2];
      result.bottom_average <= avg[3];
      result.settled        <= settled;
    end
  end

  always_comb begin
    status.worst_below = worst < GAP_W'(cfg.sweep_tol);
    status.div_done    = div_done;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lsj_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsj_ctrl: sequencer of the Laplace subdomain Jacobi solver
// Walks grid load, per-cell stencil steps, sweep ends, edge line reads and
// the four divisions, and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsj_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsj_pkg::cfg_t     cfg,
  input  wire logic              start,
  input  wire lsj_pkg::status_t  status,
  output lsj_pkg::cmd_t          cmd,
  output logic                   busy,
  output logic                   done
);
  import lsj_pkg::*;

  state_t             state, state_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;
  logic [SWEEP_W-1:0] sweep_count, sweep_count_next;
  logic [1:0]         sel, sel_next;
  logic [ROW_W-1:0]   last_row, rows_top;
  logic [COL_W-1:0]   last_col, cols_top;
  logic [SWEEP_W:0]   count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      row         <= '0;
      col         <= '0;
      sweep_count <= '0;
      sel         <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      row         <= row_next;
      col         <= col_next;
      sweep_count <= sweep_count_next;
      sel         <= sel_next;
      done        <= (state == S_FINISH);
    end
  end

  always_comb begin
    last_row  = ROW_W'(cfg.rows - ROWCNT_W'(2));
    last_col  = COL_W'(cfg.cols - COLCNT_W'(2));
    rows_top  = ROW_W'(cfg.rows - ROWCNT_W'(1));
    cols_top  = COL_W'(cfg.cols - COLCNT_W'(1));
    count_inc = {1'b0, sweep_count} + (SWEEP_W+1)'(1);

    state_next       = state;
    row_next         = row;
    col_next         = col;
    sweep_count_next = sweep_count;
    sel_next         = sel;

    cmd           = '0;
    cmd.phase     = RD_NONE;
    cmd.row       = row;
    cmd.col       = col;
    cmd.div_sel   = sel;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in  = 1'b1;
          cmd.bank_clr = 1'b1;
          row_next     = '0;
          col_next     = '0;
          state_next   = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (col == COL_W'(MAX_COLS - 1)) begin
          col_next = '0;
          if (row == ROW_W'(MAX_ROWS - 1)) begin
            sweep_count_next = '0;
            if (cfg.max_sweeps == '0) begin
              row_next   = '0;
              state_next = S_MEAN_COL;
            end else begin
              cmd.sweep_clr = 1'b1;
              row_next      = ROW_W'(1);
              col_next      = COL_W'(1);
              state_next    = S_RD0;
            end
          end else begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      S_RD0: begin
        cmd.phase  = RD_UD;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.phase  = RD_LR;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.phase  = RD_C;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_cell = 1'b1;
        state_next  = S_RD0;
        if (col == last_col) begin
          col_next = COL_W'(1);
          if (row == last_row) begin
            state_next = S_SWEEP_END;
          end else begin
            row_next = row + ROW_W'(1);
          end
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      S_SWEEP_END: begin
        cmd.swap         = 1'b1;
        sweep_count_next = count_inc[SWEEP_W-1:0];
        if (status.worst_below || count_inc >= {1'b0, cfg.max_sweeps}) begin
          row_next   = '0;
          state_next = S_MEAN_COL;
        end else begin
          cmd.sweep_clr = 1'b1;
          row_next      = ROW_W'(1);
          col_next      = COL_W'(1);
          state_next    = S_RD0;
        end
      end
      S_MEAN_COL: begin
        cmd.phase = RD_ECOL;
        if (row == rows_top) begin
          col_next   = '0;
          state_next = S_MEAN_ROW;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end
      S_MEAN_ROW: begin
        cmd.phase = RD_EROW;
        if (col == cols_top) begin
          state_next = S_MEAN_TAIL;
        end else begin
          col_next = col + COL_W'(1);
        end
      end
      S_MEAN_TAIL: begin
        // let the last row read land in its accumulator
        sel_next   = '0;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          if (sel == 2'd3) begin
            state_next = S_FINISH;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = S_DIV_GO;
          end
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/laplace_subdomain_jacobi_solver.sv =====
// ----------------------------------------------------------------------------
// laplace_subdomain_jacobi_solver: Jacobi 5-point Laplace solve per item
// Configuration registers, size clamping, controller and datapath.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is shown. An item loads all MAX_ROWS*MAX_COLS cells of the
// grid, one cell per cycle through one write port of each bank, then runs up
// to max_sweeps sweeps (each interior cell needs three two-port reads of the
// grid bank, a sum and a write), does rows + cols edge line reads and four
// divisions, one quotient bit per cycle over the 44-bit line sum. Done is high
// for a single cycle and cannot be held off; the result ports hold the result
// until the next item finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module laplace_subdomain_jacobi_solver (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire lsj_pkg::in_t                     item,
  output logic                                  done,
  output lsj_pkg::out_t                         result,
  input  wire logic                             cfg_we,
  input  wire logic [lsj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsj_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lsj_pkg::*;

  logic [DIM_W-1:0]   rows_raw, cols_raw;
  logic [SWEEP_W-1:0] max_sweeps;
  logic [TOL_W-1:0]   sweep_tol, edge_tol;
  cfg_t               cfg;
  cmd_t               cmd;
  status_t            status;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_raw   <= ROWS_RESET;
      cols_raw   <= COLS_RESET;
      max_sweeps <= MAX_SWEEPS_RESET;
      sweep_tol  <= SWEEP_TOL_RESET;
      edge_tol   <= EDGE_TOL_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ROWS:       rows_raw   <= cfg_data[DIM_W-1:0];
        REG_COLS:       cols_raw   <= cfg_data[DIM_W-1:0];
        REG_MAX_SWEEPS: max_sweeps <= cfg_data[SWEEP_W-1:0];
        REG_SWEEP_TOL:  sweep_tol  <= cfg_data[TOL_W-1:0];
        REG_EDGE_TOL:   edge_tol   <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the grid size between MIN_DIM and what the banks hold
  always_comb begin
    if (int'(rows_raw) < MIN_DIM) begin
      cfg.rows = ROWCNT_W'(MIN_DIM);
    end else if (int'(rows_raw) > MAX_ROWS) begin
      cfg.rows = ROWCNT_W'(MAX_ROWS);
    end else begin
      cfg.rows = ROWCNT_W'(rows_raw);
    end
    if (int'(cols_raw) < MIN_DIM) begin
      cfg.cols = COLCNT_W'(MIN_DIM);
    end else if (int'(cols_raw) > MAX_COLS) begin
      cfg.cols = COLCNT_W'(MAX_COLS);
    end else begin
      cfg.cols = COLCNT_W'(cols_raw);
    end
    cfg.max_sweeps = max_sweeps;
    cfg.sweep_tol  = sweep_tol;
    cfg.edge_tol   = edge_tol;
  end

  lsj_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  lsj_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lsj_checker.sv =====
// ----------------------------------------------------------------------------
// lsj_checker: port-level assertions for the Laplace subdomain solver
// Watches start, busy and done over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsj_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  // a result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  // one strobe per item
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // finishing an item always shows its result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("item finished without a result");

endmodule

bind laplace_subdomain_jacobi_solver lsj_checker u_lsj_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
